FILE: hdl/rgbycc_pkg.sv
// Shared types, constants and helpers for the RGB to YCbCr replicating scaler.
// No dependencies; imported by every module of the block.
`default_nettype none

package rgbycc_pkg;

  // fixed widths taken from the register and field definitions
  localparam int SCALE_W = 5;
  localparam int DIM_W   = 12;
  localparam int PITCH_W = 16;
  localparam int ADDR_W  = 26;
  localparam int PIX_W   = 8;
  localparam int ROW_W   = 11;
  localparam int ROW_LIMIT = 2048;

  // Q10 accumulator, signed, wide enough for every sum
  localparam int SUM_W = 20;

  // APB register map
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_HSCALE  = 3'd0,
    REG_VSCALE  = 3'd1,
    REG_S420    = 3'd2,
    REG_WIDTH   = 3'd3,
    REG_HEIGHT  = 3'd4,
    REG_LPITCH  = 3'd5,
    REG_CPITCH  = 3'd6
  } reg_idx_t;

  // BT.601 studio range, coefficients round(c*1024)
  localparam logic signed [SUM_W-1:0] Y_R   = 20'sd263;
  localparam logic signed [SUM_W-1:0] Y_G   = 20'sd516;
  localparam logic signed [SUM_W-1:0] Y_B   = 20'sd100;
  localparam logic signed [SUM_W-1:0] Y_OFF = 20'sd16384;
  localparam logic signed [SUM_W-1:0] CB_R  = -20'sd152;
  localparam logic signed [SUM_W-1:0] CB_G  = -20'sd298;
  localparam logic signed [SUM_W-1:0] CB_B  = 20'sd450;
  localparam logic signed [SUM_W-1:0] C_OFF = 20'sd131072;
  localparam logic signed [SUM_W-1:0] CR_R  = 20'sd450;
  localparam logic signed [SUM_W-1:0] CR_G  = -20'sd377;
  localparam logic signed [SUM_W-1:0] CR_B  = -20'sd73;

  // configuration register file contents
  typedef struct packed {
    logic [SCALE_W-1:0] hscale;
    logic [SCALE_W-1:0] vscale;
    logic               s420;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [PITCH_W-1:0] lpitch;
    logic [PITCH_W-1:0] cpitch;
  } cfg_t;

  // one classified pixel waiting for row replication
  typedef struct packed {
    logic [PIX_W-1:0]   y;
    logic [PIX_W-1:0]   cb;
    logic [PIX_W-1:0]   cr;
    logic [ADDR_W-1:0]  lbase;
    logic [ADDR_W-1:0]  cbase;
    logic [PITCH_W-1:0] lpitch;
    logic [PITCH_W-1:0] cpitch;
    logic [SCALE_W-1:0] vs;
    logic [SCALE_W-1:0] crow;
    logic [SCALE_W-1:0] chs;
  } entry_t;

  // negative -> 0, floor by 1024, saturate at 255
  function automatic logic [PIX_W-1:0] q10_to_byte(input logic signed [SUM_W-1:0] s);
    logic [PIX_W-1:0] res;
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (|s[SUM_W-2:18]) begin
      res = '1;
    end else begin
      res = s[17:10];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rgbycc_front.sv
// Front end: accepts pixels, forms Q10 color sums, tracks raster position and
// computes the luma/chroma base addresses. Depends on rgbycc_pkg.
`default_nettype none

module rgbycc_front #(
  parameter int MAX_SCALE = 16,
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rgbycc_pkg::cfg_t    cfg,
  input  wire logic [7:0]          red,
  input  wire logic [7:0]          green,
  input  wire logic [7:0]          blue,
  input  wire logic                pixel_valid,
  output logic                     pixel_ready,
  output rgbycc_pkg::entry_t       entry,
  output logic                     entry_valid,
  input  wire logic                entry_ready
);
  import rgbycc_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCMP_W = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
  localparam int RV_W   = ROW_W + SCALE_W;
  localparam int CH_W   = COL_W + SCALE_W;
  localparam int PROD_W = RV_W + PITCH_W;

  // raster position
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  // effective settings
  logic [SCALE_W-1:0] hs, vs, chs, cvs, crow;
  logic [WCMP_W-1:0]  eff_w, col_inc;
  logic [DIM_W-1:0]   eff_h, row_inc;
  logic               accept;

  // stage 1 registers
  logic                     s1_valid;
  logic signed [SUM_W-1:0]  y_sum, cb_sum, cr_sum;
  logic [RV_W-1:0]          rowvs, rowcr;
  logic [CH_W-1:0]          colh, colc;
  logic [PITCH_W-1:0]       lp, cp;
  logic [SCALE_W-1:0]       s1_vs, s1_crow, s1_chs;

  // stage 2 products
  logic [PROD_W-1:0] lprod, cprod;
  logic signed [SUM_W-1:0] r_s, g_s, b_s;

  // scale and dimension clamping
  always_comb begin
    if (cfg.hscale == '0) begin
      hs = SCALE_W'(1);
    end else if (int'(cfg.hscale) > MAX_SCALE) begin
      hs = SCALE_W'(MAX_SCALE);
    end else begin
      hs = cfg.hscale;
    end
    if (cfg.vscale == '0) begin
      vs = SCALE_W'(1);
    end else if (int'(cfg.vscale) > MAX_SCALE) begin
      vs = SCALE_W'(MAX_SCALE);
    end else begin
      vs = cfg.vscale;
    end
    chs  = cfg.s420 ? (hs >> 1) : hs;
    cvs  = cfg.s420 ? (vs >> 1) : vs;
    crow = (cvs == '0) ? SCALE_W'(1) : cvs;

    if (cfg.width == '0) begin
      eff_w = WCMP_W'(1);
    end else if (int'(cfg.width) > MAX_WIDTH) begin
      eff_w = WCMP_W'(MAX_WIDTH);
    end else begin
      eff_w = WCMP_W'(cfg.width);
    end
    if (cfg.height == '0) begin
      eff_h = DIM_W'(1);
    end else if (int'(cfg.height) > ROW_LIMIT) begin
      eff_h = DIM_W'(ROW_LIMIT);
    end else begin
      eff_h = cfg.height;
    end
    col_inc = WCMP_W'(col) + WCMP_W'(1);
    row_inc = DIM_W'(row) + DIM_W'(1);
  end

  assign pixel_ready = !s1_valid || entry_ready;
  assign accept      = pixel_valid && pixel_ready;

  assign r_s = $signed({{(SUM_W-PIX_W){1'b0}}, red});
  assign g_s = $signed({{(SUM_W-PIX_W){1'b0}}, green});
  assign b_s = $signed({{(SUM_W-PIX_W){1'b0}}, blue});

  // control: stage valid and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      col      <= '0;
      row      <= '0;
    end else begin
      if (pixel_ready) s1_valid <= pixel_valid;
      if (accept) begin
        if (col_inc >= eff_w) begin
          col <= '0;
          row <= (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
        end else begin
          col <= col_inc[COL_W-1:0];
        end
      end
    end
  end

  // stage 1 payload: color sums and first-level products
  always_ff @(posedge clk) begin
    if (accept) begin
      y_sum   <= Y_R * r_s + Y_G * g_s + Y_B * b_s + Y_OFF;
      cb_sum  <= CB_R * r_s + CB_G * g_s + CB_B * b_s + C_OFF;
      cr_sum  <= CR_R * r_s + CR_G * g_s + CR_B * b_s + C_OFF;
      rowvs   <= RV_W'(row) * RV_W'(vs);
      rowcr   <= RV_W'(row) * RV_W'(crow);
      colh    <= CH_W'(col) * CH_W'(hs);
      colc    <= CH_W'(col) * CH_W'(chs);
      lp      <= cfg.lpitch;
      cp      <= cfg.cpitch;
      s1_vs   <= vs;
      s1_crow <= crow;
      s1_chs  <= chs;
    end
  end

  // stage 2: row offset times pitch, plus column offset
  assign lprod = PROD_W'(rowvs) * PROD_W'(lp);
  assign cprod = PROD_W'(rowcr) * PROD_W'(cp);

  always_comb begin
    entry.y      = q10_to_byte(y_sum);
    entry.cb     = q10_to_byte(cb_sum);
    entry.cr     = q10_to_byte(cr_sum);
    entry.lbase  = lprod[ADDR_W-1:0] + ADDR_W'(colh);
    entry.cbase  = cprod[ADDR_W-1:0] + ADDR_W'(colc);
    entry.lpitch = lp;
    entry.cpitch = cp;
    entry.vs     = s1_vs;
    entry.crow   = s1_crow;
    entry.chs    = s1_chs;
  end

  assign entry_valid = s1_valid;

endmodule

`default_nettype wire

FILE: hdl/rgbycc_queue.sv
// Short FIFO of classified pixels between front and back end.
// Depends on rgbycc_pkg for the entry type.
`default_nettype none

module rgbycc_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rgbycc_pkg::entry_t  in_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output rgbycc_pkg::entry_t       out_data,
  output logic                     out_valid,
  input  wire logic                out_ready
);
  import rgbycc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t            slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push, pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_data;
  end

endmodule

`default_nettype wire

FILE: hdl/rgbycc_back.sv
// Back end: replicates each pixel over its luma rows, stepping the plane
// addresses by the pitches, into a registered result word. Depends on rgbycc_pkg.
`default_nettype none

module rgbycc_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rgbycc_pkg::entry_t  entry,
  input  wire logic                entry_valid,
  output logic                     entry_ready,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output logic [7:0]               luma_value,
  output logic [7:0]               blue_diff_value,
  output logic [7:0]               red_diff_value,
  output logic [25:0]              luma_address,
  output logic [25:0]              chroma_address,
  output logic [4:0]               chroma_run,
  output logic                     chroma_valid,
  output logic                     last_of_pixel
);
  import rgbycc_pkg::*;

  entry_t             cur;
  logic               active;
  logic [SCALE_W-1:0] k;
  logic [ADDR_W-1:0]  la, ca;
  logic               out_free, step, last_row, last_step, load, cv;

  assign out_free    = !result_valid || result_ready;
  assign step        = active && out_free;
  assign last_row    = (k == cur.vs - SCALE_W'(1));
  assign last_step   = step && last_row;
  assign entry_ready = !active || last_step;
  assign load        = entry_ready && entry_valid;
  assign cv          = (k < cur.crow);

  // control: busy flag and output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        active <= 1'b1;
      end else if (last_step) begin
        active <= 1'b0;
      end
      if (step) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // row iteration and address stepping
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= entry;
      k   <= '0;
      la  <= entry.lbase;
      ca  <= entry.cbase;
    end else if (step) begin
      k  <= k + SCALE_W'(1);
      la <= la + ADDR_W'(cur.lpitch);
      ca <= ca + ADDR_W'(cur.cpitch);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (step) begin
      luma_value      <= cur.y;
      blue_diff_value <= cur.cb;
      red_diff_value  <= cur.cr;
      luma_address    <= la;
      chroma_address  <= cv ? ca : '0;
      chroma_run      <= cv ? cur.chs : '0;
      chroma_valid    <= cv;
      last_of_pixel   <= last_row;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rgb_to_ycbcr_replicating_scaler.sv
// RGB888 to BT.601 YCbCr with integer row replication. Throughput: one result
// word per cycle while result_ready is held high, so a pixel occupies the back
// end for its effective vertical scale (1..MAX_SCALE) result words; the
// row-replication counter in the back end sets this figure.
// Synchronous reset clears registers to defaults, counters to zero, pipe empty.
`default_nettype none

module rgb_to_ycbcr_replicating_scaler #(
  parameter int MAX_SCALE = 16,
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // pixel channel
  input  wire logic        pixel_valid,
  output logic             pixel_ready,
  input  wire logic [7:0]  red,
  input  wire logic [7:0]  green,
  input  wire logic [7:0]  blue,
  // result channel
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [7:0]       luma_value,
  output logic [7:0]       blue_diff_value,
  output logic [7:0]       red_diff_value,
  output logic [25:0]      luma_address,
  output logic [25:0]      chroma_address,
  output logic [4:0]       chroma_run,
  output logic             chroma_valid,
  output logic             last_of_pixel
);
  import rgbycc_pkg::*;

  cfg_t     cfg;
  reg_idx_t idx;
  logic     wr_en;
  entry_t   f_entry, q_entry;
  logic     f_valid, f_ready, q_valid, q_ready;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hscale <= SCALE_W'(1);
      cfg.vscale <= SCALE_W'(1);
      cfg.s420   <= 1'b0;
      cfg.width  <= DIM_W'(640);
      cfg.height <= DIM_W'(480);
      cfg.lpitch <= PITCH_W'(640);
      cfg.cpitch <= PITCH_W'(640);
    end else if (wr_en) begin
      unique case (idx)
        REG_HSCALE: cfg.hscale <= pwdata[SCALE_W-1:0];
        REG_VSCALE: cfg.vscale <= pwdata[SCALE_W-1:0];
        REG_S420:   cfg.s420   <= pwdata[0];
        REG_WIDTH:  cfg.width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg.height <= pwdata[DIM_W-1:0];
        REG_LPITCH: cfg.lpitch <= pwdata[PITCH_W-1:0];
        REG_CPITCH: cfg.cpitch <= pwdata[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (idx)
      REG_HSCALE: prdata = PDATA_W'(cfg.hscale);
      REG_VSCALE: prdata = PDATA_W'(cfg.vscale);
      REG_S420:   prdata = PDATA_W'(cfg.s420);
      REG_WIDTH:  prdata = PDATA_W'(cfg.width);
      REG_HEIGHT: prdata = PDATA_W'(cfg.height);
      REG_LPITCH: prdata = PDATA_W'(cfg.lpitch);
      REG_CPITCH: prdata = PDATA_W'(cfg.cpitch);
      default:    prdata = '0;
    endcase
  end

  rgbycc_front #(
    .MAX_SCALE (MAX_SCALE),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .entry       (f_entry),
    .entry_valid (f_valid),
    .entry_ready (f_ready)
  );

  rgbycc_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_data   (f_entry),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_data  (q_entry),
    .out_valid (q_valid),
    .out_ready (q_ready)
  );

  rgbycc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .entry           (q_entry),
    .entry_valid     (q_valid),
    .entry_ready     (q_ready),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .luma_value      (luma_value),
    .blue_diff_value (blue_diff_value),
    .red_diff_value  (red_diff_value),
    .luma_address    (luma_address),
    .chroma_address  (chroma_address),
    .chroma_run      (chroma_run),
    .chroma_valid    (chroma_valid),
    .last_of_pixel   (last_of_pixel)
  );

  // non-chroma rows carry zero chroma address and run
  a_no_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !chroma_valid |-> chroma_run == '0 && chroma_address == '0)
    else $error("chroma fields set on a luma-only row");

  // a taken row that is not the pixel's last is followed at once by the next row
  a_rows_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !last_of_pixel |=> result_valid)
    else $error("gap inside a pixel's replicated rows");

  // reset leaves the result channel empty
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result word present after reset");

endmodule

`default_nettype wire

FILE: sim/rgb_to_ycbcr_replicating_scaler_tb.sv
// Self-checking bench for rgb_to_ycbcr_replicating_scaler: drives RGB pixels, programs
// the APB registers and checks every replicated row word against an in-bench predictor.
// Depends on rgbycc_pkg (widths, register indexes) and the block itself.
`timescale 1ns / 100ps

module rgb_to_ycbcr_replicating_scaler_tb;
  import rgbycc_pkg::*;

  localparam int SCALE_MAX = 16;
  localparam int WIDTH_MAX = 2048;

  // one replicated luma row as the block reports it
  typedef struct {
    logic [PIX_W-1:0]   y;
    logic [PIX_W-1:0]   cb;
    logic [PIX_W-1:0]   cr;
    logic [ADDR_W-1:0]  laddr;
    logic [ADDR_W-1:0]  caddr;
    logic [SCALE_W-1:0] crun;
    logic               cflag;
    logic               last;
  } row_word_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;
  logic pixel_valid, pixel_ready;
  logic [PIX_W-1:0] red, green, blue;
  logic result_valid, result_ready;
  logic [PIX_W-1:0] luma_value, blue_diff_value, red_diff_value;
  logic [ADDR_W-1:0] luma_address, chroma_address;
  logic [SCALE_W-1:0] chroma_run;
  logic chroma_valid, last_of_pixel;

  // predictor copy of the registers and raster counters
  logic [SCALE_W-1:0] cfg_hscale, cfg_vscale;
  logic               cfg_s420;
  logic [DIM_W-1:0]   cfg_width, cfg_height;
  logic [PITCH_W-1:0] cfg_lpitch, cfg_cpitch;
  int col_pos, row_pos;

  row_word_t pending_rows[$];
  int mismatches;
  bit tx_idle, rx_idle;
  int drain_hold;

  rgb_to_ycbcr_replicating_scaler dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .red(red), .green(green), .blue(blue),
    .result_valid(result_valid), .result_ready(result_ready),
    .luma_value(luma_value), .blue_diff_value(blue_diff_value),
    .red_diff_value(red_diff_value), .luma_address(luma_address),
    .chroma_address(chroma_address), .chroma_run(chroma_run),
    .chroma_valid(chroma_valid), .last_of_pixel(last_of_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("rgb_to_ycbcr_replicating_scaler_tb: FAIL");
    $finish;
  end

  function automatic int clamp_to(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Q10 sum to byte: negative gives 0, floor, saturate at 255
  function automatic logic [PIX_W-1:0] sat_q10(input int acc);
    int q;
    if (acc < 0) return 8'd0;
    q = acc / 1024;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  // convert one pixel, queue its replicated rows, then step the raster counters
  function automatic void convert_and_replicate(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
    int ri, gi, bi, hs, vs, chs, crow, w, h, k;
    longint la, ca;
    row_word_t word;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    word.y  = sat_q10(263 * ri + 516 * gi + 100 * bi + 16 * 1024);
    word.cb = sat_q10(-152 * ri - 298 * gi + 450 * bi + 128 * 1024);
    word.cr = sat_q10(450 * ri - 377 * gi - 73 * bi + 128 * 1024);
    hs = clamp_to(int'(cfg_hscale), 1, SCALE_MAX);
    vs = clamp_to(int'(cfg_vscale), 1, SCALE_MAX);
    chs = cfg_s420 ? hs / 2 : hs;
    crow = cfg_s420 ? vs / 2 : vs;
    if (crow < 1) crow = 1;
    w = clamp_to(int'(cfg_width), 1, WIDTH_MAX);
    h = clamp_to(int'(cfg_height), 1, ROW_LIMIT);
    for (k = 0; k < vs; k++) begin
      la = (longint'(row_pos) * vs + k) * cfg_lpitch + longint'(col_pos) * hs;
      word.laddr = la[ADDR_W-1:0];
      word.cflag = (k < crow);
      if (word.cflag) begin
        ca = (longint'(row_pos) * crow + k) * cfg_cpitch + longint'(col_pos) * chs;
        word.caddr = ca[ADDR_W-1:0];
        word.crun = chs[SCALE_W-1:0];
      end else begin
        word.caddr = '0;
        word.crun = '0;
      end
      word.last = (k == vs - 1);
      pending_rows.push_back(word);
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic void flag_mismatch(input string what, input row_word_t got,
                                        input row_word_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: got y=%0d cb=%0d cr=%0d la=%h ca=%h run=%0d cv=%b last=%b",
               $realtime, what, got.y, got.cb, got.cr, got.laddr, got.caddr, got.crun,
               got.cflag, got.last);
      $display("        want y=%0d cb=%0d cr=%0d la=%h ca=%h run=%0d cv=%b last=%b",
               want.y, want.cb, want.cr, want.laddr, want.caddr, want.crun,
               want.cflag, want.last);
    end
  endfunction

  // result side: check each accepted word, then pick the next ready
  initial begin : result_sink
    row_word_t got, want;
    int wait_left;
    logic ready_nxt;
    wait_left = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        got.y = luma_value;
        got.cb = blue_diff_value;
        got.cr = red_diff_value;
        got.laddr = luma_address;
        got.caddr = chroma_address;
        got.crun = chroma_run;
        got.cflag = chroma_valid;
        got.last = last_of_pixel;
        if (pending_rows.size() == 0) begin
          flag_mismatch("word with nothing expected", got, got);
        end else begin
          want = pending_rows.pop_front();
          if (got.y !== want.y || got.cb !== want.cb || got.cr !== want.cr ||
              got.laddr !== want.laddr || got.caddr !== want.caddr ||
              got.crun !== want.crun || got.cflag !== want.cflag ||
              got.last !== want.last)
            flag_mismatch("row word mismatch", got, want);
        end
        wait_left = rx_idle ? $urandom_range(0, 15) : 0;
      end
      if (rst) begin
        ready_nxt = 1'b0;
      end else if (drain_hold > 0) begin
        // long hold-off so the block backs up into the pixel side
        drain_hold--;
        ready_nxt = 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
      end
      result_ready <= ready_nxt;
    end
  end

  // APB write: setup, access, then back to idle; mirrors the value into the predictor
  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_HSCALE: cfg_hscale = val[SCALE_W-1:0];
      REG_VSCALE: cfg_vscale = val[SCALE_W-1:0];
      REG_S420:   cfg_s420 = val[0];
      REG_WIDTH:  cfg_width = val[DIM_W-1:0];
      REG_HEIGHT: cfg_height = val[DIM_W-1:0];
      REG_LPITCH: cfg_lpitch = val[PITCH_W-1:0];
      REG_CPITCH: cfg_cpitch = val[PITCH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int hs, input int vs, input int s420, input int w,
                            input int h, input int lp, input int cp);
    apb_write(REG_HSCALE, hs);
    apb_write(REG_VSCALE, vs);
    apb_write(REG_S420, s420);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
    apb_write(REG_LPITCH, lp);
    apb_write(REG_CPITCH, cp);
  endtask

  // offer one pixel word; valid stays high afterwards unless a gap follows
  task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (!pixel_ready);
    convert_and_replicate(r, g, b);
  endtask

  task automatic send_random_pixel();
    send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
               PIX_W'($urandom_range(0, 255)));
  endtask

  // drop valid and wait until every expected word is back, plus pipeline slack
  task automatic settle();
    pixel_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // reset defaults, color corners and midpoints
  task automatic test_color_corners();
    tx_idle = 1;
    rx_idle = 1;
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd127, 8'd1);
    settle();
  endtask

  // largest scales and pitches, zero scale acting as 1, oversize scale clamped
  task automatic test_scale_limits();
    set_config(16, 16, 0, 2, 2, 65535, 65535);
    send_random_pixel();
    send_random_pixel();
    settle();
    set_config(0, 0, 0, 2, 2, 0, 0);
    send_random_pixel();
    settle();
    set_config(31, 31, 0, 2, 2, 300, 200);
    send_random_pixel();
    send_random_pixel();
    settle();
  endtask

  // 4:2:0: chroma halves to zero at scale 1, odd scales, full scale
  task automatic test_subsample();
    set_config(1, 1, 1, 3, 2, 100, 50);
    send_random_pixel();
    send_random_pixel();
    settle();
    set_config(7, 5, 1, 3, 2, 1000, 700);
    send_random_pixel();
    send_random_pixel();
    settle();
    set_config(16, 16, 1, 3, 2, 4096, 2048);
    send_random_pixel();
    settle();
  endtask

  // small frame so the column wraps; zero size acting as 1, so column and row wrap
  task automatic test_counter_wrap();
    set_config(2, 3, 0, 3, 2, 40, 30);
    repeat (4) send_random_pixel();
    settle();
    set_config(2, 2, 0, 0, 0, 40, 30);
    repeat (2) send_random_pixel();
    settle();
  endtask

  // oversize width and height clamp to the limits; a tall one-pixel-wide frame
  // at full scale and pitch runs the row offsets past the 26-bit address range
  task automatic test_dimension_limits();
    tx_idle = 0;
    rx_idle = 0;
    set_config(1, 1, 0, 4095, 4095, 65535, 65535);
    repeat (4) send_random_pixel();
    settle();
    set_config(16, 16, 0, 1, 4095, 65535, 65535);
    repeat (70) send_random_pixel();
    settle();
  endtask

  // hold the result side long enough that the block stops taking pixels
  task automatic test_backpressure();
    tx_idle = 0;
    rx_idle = 0;
    set_config(3, 16, 0, 5, 4, 777, 333);
    drain_hold = 400;
    repeat (24) send_random_pixel();
    settle();
  endtask

  // random phases: random settings, mostly small scales and frames
  task automatic test_random_stream();
    int phase, hs, vs, w, h;
    for (phase = 0; phase < 3; phase++) begin
      hs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      vs = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 6);
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 4);
      set_config(hs, vs, $urandom_range(0, 1), w, h,
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      repeat (12) send_random_pixel();
      settle();
    end
  endtask

  initial begin : test_sequence
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pixel_valid <= 1'b0;
    red <= '0;
    green <= '0;
    blue <= '0;
    cfg_hscale = 5'd1;
    cfg_vscale = 5'd1;
    cfg_s420 = 1'b0;
    cfg_width = 12'd640;
    cfg_height = 12'd480;
    cfg_lpitch = 16'd640;
    cfg_cpitch = 16'd640;
    col_pos = 0;
    row_pos = 0;
    mismatches = 0;
    drain_hold = 0;
    tx_idle = 0;
    rx_idle = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_color_corners();
    test_scale_limits();
    test_subsample();
    test_counter_wrap();
    test_backpressure();
    test_dimension_limits();
    test_random_stream();

    if (mismatches == 0) begin
      $display("rgb_to_ycbcr_replicating_scaler_tb: PASS");
    end else begin
      $display("rgb_to_ycbcr_replicating_scaler_tb: FAIL");
    end
    $finish;
  end

endmodule
